[hw/rtl/dual_pool_first_fit_allocator_defines.svh]
// Assertion macros for the allocator.
`ifndef DUAL_POOL_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define DUAL_POOL_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define DPFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpfa assertion failed");

// next-cycle implication
`define DPFA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpfa assertion failed");

`endif

[hw/rtl/dpfa_pkg.sv]
`default_nettype none
package dpfa_pkg;

  localparam int CNT_W  = 25;
  localparam int BASE_W = 24;

  localparam logic [CNT_W-1:0] LEN_MAX = '1;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_MAX_VERTICES = 2'd0;
  localparam logic [1:0] REG_MAX_INDICES  = 2'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_VEXH     = 3'd2;
  localparam logic [2:0] ST_IEXH     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  typedef struct packed {
    logic [1:0]        command;
    logic [CNT_W-1:0]  vertex_count;
    logic [CNT_W-1:0]  index_count;
    logic [BASE_W-1:0] vertex_start;
    logic [BASE_W-1:0] index_start;
    logic              alloc_valid;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [BASE_W-1:0] vertex_base;
    logic [BASE_W-1:0] index_base;
    logic [CNT_W-1:0]  vertices_in_use;
    logic [CNT_W-1:0]  indices_in_use;
  } out_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] len;
  } entry_t;

  typedef enum logic {POOL_V, POOL_I} pool_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_TK_RD, S_TK_CHK, S_LC_RD, S_LC_CHK, S_LOC_DONE,
    S_SHL_RD, S_SHL_WR, S_SHR_RD, S_SHR_WR, S_NEXT, S_RESP
  } state_t;

  typedef enum logic [2:0] {
    PH_TAKE_V, PH_TAKE_I, PH_ROLLBACK, PH_CHK_V, PH_CHK_I, PH_FREE_V, PH_FREE_I
  } phase_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_START, OP_SCAN_RD, OP_TAKE_CHK, OP_LOC_CHK,
    OP_MERGE_BOTH, OP_MERGE_NEXT, OP_MERGE_PREV, OP_SHR_INIT, OP_SHR_RD,
    OP_SHR_WR, OP_INSERT, OP_SHL_RD, OP_SHL_WR, OP_SHL_END, OP_CLEAR,
    OP_FINISH, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    pool_t      pool;
    logic       use_base;
    logic [2:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       pools_ready;
    logic       alloc_valid;
    logic       vc_zero;
    logic       ic_zero;
    logic       hit;
    logic       scan_end;
    logic       len_ge;
    logic       len_eq;
    logic       lt;
    logic       mn;
    logic       mp;
    logic       fits;
    logic       cnt_zero;
    logic       shl_more;
    logic       shr_more;
    logic       list_full;
    logic       out_full;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] sat_len(input logic [CNT_W+1:0] v);
    return (v > {2'b00, LEN_MAX}) ? LEN_MAX : v[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? LEN_MAX : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/dpfa_ctrl.sv]
`default_nettype none
module dpfa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               out_ready,
  input  wire dpfa_pkg::dp_stat_t stat,
  output dpfa_pkg::dp_cmd_t       cmd
);

  dpfa_pkg::state_t state, state_next;
  dpfa_pkg::phase_t phase, phase_next;

  logic reject;
  logic chk_ok;
  logic apply_phase;

  assign reject = !stat.pools_ready || stat.vc_zero || stat.ic_zero;
  assign chk_ok = stat.cnt_zero || stat.fits;
  assign apply_phase = (phase == dpfa_pkg::PH_ROLLBACK) || (phase == dpfa_pkg::PH_FREE_V) ||
                       (phase == dpfa_pkg::PH_FREE_I);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpfa_pkg::S_IDLE;
      phase <= dpfa_pkg::PH_TAKE_V;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      dpfa_pkg::S_IDLE: if (in_valid) state_next = dpfa_pkg::S_DISPATCH;
      dpfa_pkg::S_DISPATCH: begin
        priority if (stat.command == dpfa_pkg::CMD_ALLOC) begin
          if (reject) begin
            state_next = dpfa_pkg::S_RESP;
          end else begin
            phase_next = dpfa_pkg::PH_TAKE_V;
            state_next = dpfa_pkg::S_TK_RD;
          end
        end else if (stat.command == dpfa_pkg::CMD_FREE) begin
          if (!stat.alloc_valid) begin
            state_next = dpfa_pkg::S_RESP;
          end else begin
            phase_next = dpfa_pkg::PH_CHK_V;
            state_next = dpfa_pkg::S_LC_RD;
          end
        end else begin
          state_next = dpfa_pkg::S_RESP;
        end
      end
      dpfa_pkg::S_TK_RD: state_next = stat.scan_end ? dpfa_pkg::S_NEXT : dpfa_pkg::S_TK_CHK;
      dpfa_pkg::S_TK_CHK: begin
        priority if (stat.len_ge && stat.len_eq) state_next = dpfa_pkg::S_SHL_RD;
        else if (stat.len_ge) state_next = dpfa_pkg::S_NEXT;
        else state_next = dpfa_pkg::S_TK_RD;
      end
      dpfa_pkg::S_LC_RD: state_next = stat.scan_end ? dpfa_pkg::S_LOC_DONE : dpfa_pkg::S_LC_CHK;
      dpfa_pkg::S_LC_CHK: state_next = stat.lt ? dpfa_pkg::S_LC_RD : dpfa_pkg::S_LOC_DONE;
      dpfa_pkg::S_LOC_DONE: begin
        if (apply_phase) begin
          priority if (stat.cnt_zero || !stat.fits) state_next = dpfa_pkg::S_NEXT;
          else if (stat.mn && stat.mp) state_next = dpfa_pkg::S_SHL_RD;
          else if (stat.mn || stat.mp) state_next = dpfa_pkg::S_NEXT;
          else state_next = dpfa_pkg::S_SHR_RD;
        end else if (!chk_ok) begin
          state_next = dpfa_pkg::S_RESP;
        end else begin
          phase_next = (phase == dpfa_pkg::PH_CHK_V) ? dpfa_pkg::PH_CHK_I : dpfa_pkg::PH_FREE_V;
          state_next = dpfa_pkg::S_LC_RD;
        end
      end
      dpfa_pkg::S_SHL_RD: state_next = stat.shl_more ? dpfa_pkg::S_SHL_WR : dpfa_pkg::S_NEXT;
      dpfa_pkg::S_SHL_WR: state_next = dpfa_pkg::S_SHL_RD;
      dpfa_pkg::S_SHR_RD: state_next = stat.shr_more ? dpfa_pkg::S_SHR_WR : dpfa_pkg::S_NEXT;
      dpfa_pkg::S_SHR_WR: state_next = dpfa_pkg::S_SHR_RD;
      dpfa_pkg::S_NEXT: begin
        unique case (phase)
          dpfa_pkg::PH_TAKE_V: begin
            if (stat.hit) begin
              phase_next = dpfa_pkg::PH_TAKE_I;
              state_next = dpfa_pkg::S_TK_RD;
            end else begin
              state_next = dpfa_pkg::S_RESP;
            end
          end
          dpfa_pkg::PH_TAKE_I: begin
            if (stat.hit) begin
              state_next = dpfa_pkg::S_RESP;
            end else begin
              phase_next = dpfa_pkg::PH_ROLLBACK;
              state_next = dpfa_pkg::S_LC_RD;
            end
          end
          dpfa_pkg::PH_FREE_V: begin
            phase_next = dpfa_pkg::PH_FREE_I;
            state_next = dpfa_pkg::S_LC_RD;
          end
          default: state_next = dpfa_pkg::S_RESP;
        endcase
      end
      dpfa_pkg::S_RESP: if (!stat.out_full || out_ready) state_next = dpfa_pkg::S_IDLE;
      default: state_next = dpfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op = dpfa_pkg::OP_IDLE;
    cmd.pool = ((phase == dpfa_pkg::PH_TAKE_I) || (phase == dpfa_pkg::PH_CHK_I) ||
                (phase == dpfa_pkg::PH_FREE_I)) ? dpfa_pkg::POOL_I : dpfa_pkg::POOL_V;
    cmd.use_base = (phase == dpfa_pkg::PH_ROLLBACK);
    cmd.status = dpfa_pkg::ST_OK;
    unique case (state)
      dpfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.op = dpfa_pkg::OP_LOAD;
      end
      dpfa_pkg::S_DISPATCH: begin
        priority if (stat.command == dpfa_pkg::CMD_ALLOC) begin
          if (reject) begin
            cmd.op = dpfa_pkg::OP_FINISH;
            cmd.status = dpfa_pkg::ST_REJECTED;
          end else begin
            cmd.op = dpfa_pkg::OP_START;
          end
        end else if (stat.command == dpfa_pkg::CMD_FREE) begin
          if (!stat.alloc_valid) begin
            cmd.op = dpfa_pkg::OP_FINISH;
            cmd.status = dpfa_pkg::ST_IGNORED;
          end else begin
            cmd.op = dpfa_pkg::OP_START;
          end
        end else if (stat.command == dpfa_pkg::CMD_CLEAR) begin
          cmd.op = dpfa_pkg::OP_CLEAR;
        end else begin
          cmd.op = dpfa_pkg::OP_FINISH;
          cmd.status = dpfa_pkg::ST_IGNORED;
        end
      end
      dpfa_pkg::S_TK_RD, dpfa_pkg::S_LC_RD:
        if (!stat.scan_end) cmd.op = dpfa_pkg::OP_SCAN_RD;
      dpfa_pkg::S_TK_CHK: cmd.op = dpfa_pkg::OP_TAKE_CHK;
      dpfa_pkg::S_LC_CHK: cmd.op = dpfa_pkg::OP_LOC_CHK;
      dpfa_pkg::S_LOC_DONE: begin
        if (apply_phase) begin
          priority if (stat.cnt_zero || !stat.fits) cmd.op = dpfa_pkg::OP_IDLE;
          else if (stat.mn && stat.mp) cmd.op = dpfa_pkg::OP_MERGE_BOTH;
          else if (stat.mn) cmd.op = dpfa_pkg::OP_MERGE_NEXT;
          else if (stat.mp) cmd.op = dpfa_pkg::OP_MERGE_PREV;
          else cmd.op = dpfa_pkg::OP_SHR_INIT;
        end else if (chk_ok) begin
          cmd.op = dpfa_pkg::OP_START;
        end else begin
          cmd.op = dpfa_pkg::OP_FINISH;
          cmd.status = dpfa_pkg::ST_FULL;
        end
      end
      dpfa_pkg::S_SHL_RD:
        cmd.op = stat.shl_more ? dpfa_pkg::OP_SHL_RD : dpfa_pkg::OP_SHL_END;
      dpfa_pkg::S_SHL_WR: cmd.op = dpfa_pkg::OP_SHL_WR;
      dpfa_pkg::S_SHR_RD:
        cmd.op = stat.shr_more ? dpfa_pkg::OP_SHR_RD : dpfa_pkg::OP_INSERT;
      dpfa_pkg::S_SHR_WR: cmd.op = dpfa_pkg::OP_SHR_WR;
      dpfa_pkg::S_NEXT: begin
        unique case (phase)
          dpfa_pkg::PH_TAKE_V: begin
            if (stat.hit) begin
              cmd.op = dpfa_pkg::OP_START;
            end else begin
              cmd.op = dpfa_pkg::OP_FINISH;
              cmd.status = dpfa_pkg::ST_VEXH;
            end
          end
          dpfa_pkg::PH_TAKE_I: cmd.op = stat.hit ? dpfa_pkg::OP_FINISH : dpfa_pkg::OP_START;
          dpfa_pkg::PH_ROLLBACK: begin
            cmd.op = dpfa_pkg::OP_FINISH;
            cmd.status = dpfa_pkg::ST_IEXH;
          end
          dpfa_pkg::PH_FREE_V: cmd.op = dpfa_pkg::OP_START;
          dpfa_pkg::PH_FREE_I: cmd.op = dpfa_pkg::OP_FINISH;
          default: begin
            cmd.op = dpfa_pkg::OP_FINISH;
            cmd.status = dpfa_pkg::ST_IGNORED;
          end
        endcase
      end
      dpfa_pkg::S_RESP: if (!stat.out_full || out_ready) cmd.op = dpfa_pkg::OP_OUT;
      default: cmd.op = dpfa_pkg::OP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/dpfa_datapath.sv]
`default_nettype none
module dpfa_datapath #(
  parameter int FREE_BLOCKS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dpfa_pkg::in_beat_t    in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [dpfa_pkg::CNT_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output dpfa_pkg::out_beat_t        out_data,
  input  wire dpfa_pkg::dp_cmd_t     cmd,
  output dpfa_pkg::dp_stat_t         stat
);

  localparam int IW = $clog2(FREE_BLOCKS);
  localparam int TW = $clog2(FREE_BLOCKS + 1);
  localparam int CW = dpfa_pkg::CNT_W;

  dpfa_pkg::in_beat_t item;
  logic [CW-1:0] max_v, max_i;
  logic [CW-1:0] vused, iused;
  logic [TW-1:0] vtot, itot;
  logic [TW-1:0] idx, j;
  logic          pools_ready;
  logic          hit;
  logic [CW-1:0] vb, ib;
  logic [2:0]    res_status;
  dpfa_pkg::entry_t prev, cur;

  dpfa_pkg::entry_t vmem [FREE_BLOCKS];
  dpfa_pkg::entry_t imem [FREE_BLOCKS];
  dpfa_pkg::entry_t vrd, ird;

  logic [TW-1:0]    total;
  logic [CW-1:0]    cnt, off;
  dpfa_pkg::entry_t rd;
  logic [TW-1:0]    jm1, jp1, idxm1, idxp1;
  logic [IW-1:0]    ra, wa;
  logic             we;
  dpfa_pkg::entry_t wd;
  logic             vwe, iwe;
  logic [IW-1:0]    vwa, iwa;
  dpfa_pkg::entry_t vwd, iwd;
  logic             is_pool_i;

  assign is_pool_i = (cmd.pool == dpfa_pkg::POOL_I);
  assign total = is_pool_i ? itot : vtot;
  assign cnt = is_pool_i ? item.index_count : item.vertex_count;
  assign off = cmd.use_base ? vb :
               {1'b0, (is_pool_i ? item.index_start : item.vertex_start)};
  assign rd = is_pool_i ? ird : vrd;
  assign jm1 = j - TW'(1);
  assign jp1 = j + TW'(1);
  assign idxm1 = idx - TW'(1);
  assign idxp1 = idx + TW'(1);

  always_comb begin
    stat.command = item.command;
    stat.pools_ready = pools_ready;
    stat.alloc_valid = item.alloc_valid;
    stat.vc_zero = (item.vertex_count == '0);
    stat.ic_zero = (item.index_count == '0);
    stat.hit = hit;
    stat.scan_end = (idx >= total);
    stat.len_ge = (rd.len >= cnt);
    stat.len_eq = (rd.len == cnt);
    stat.lt = (rd.start < off);
    stat.mn = (idx < total) && (({1'b0, off} + {1'b0, cnt}) == {1'b0, cur.start});
    stat.mp = (idx != '0) && (({1'b0, prev.start} + {1'b0, prev.len}) == {1'b0, off});
    stat.list_full = (total >= TW'(FREE_BLOCKS));
    stat.fits = stat.mn || stat.mp || !stat.list_full;
    stat.cnt_zero = (cnt == '0);
    stat.shl_more = (jp1 < total);
    stat.shr_more = (j > idx);
    stat.out_full = out_valid;
  end

  always_comb begin
    ra = idx[IW-1:0];
    we = 1'b0;
    wa = idx[IW-1:0];
    wd = rd;
    unique case (cmd.op)
      dpfa_pkg::OP_SHR_RD: ra = jm1[IW-1:0];
      dpfa_pkg::OP_SHL_RD: ra = jp1[IW-1:0];
      dpfa_pkg::OP_TAKE_CHK: begin
        we = stat.len_ge && !stat.len_eq;
        wd.start = rd.start + cnt;
        wd.len = rd.len - cnt;
      end
      dpfa_pkg::OP_MERGE_BOTH: begin
        we = 1'b1;
        wa = idxm1[IW-1:0];
        wd.start = prev.start;
        wd.len = dpfa_pkg::sat_len({2'b00, prev.len} + {2'b00, cnt} + {2'b00, cur.len});
      end
      dpfa_pkg::OP_MERGE_NEXT: begin
        we = 1'b1;
        wd.start = off;
        wd.len = dpfa_pkg::sat_len({2'b00, cnt} + {2'b00, cur.len});
      end
      dpfa_pkg::OP_MERGE_PREV: begin
        we = 1'b1;
        wa = idxm1[IW-1:0];
        wd.start = prev.start;
        wd.len = dpfa_pkg::sat_len({2'b00, prev.len} + {2'b00, cnt});
      end
      dpfa_pkg::OP_SHR_WR, dpfa_pkg::OP_SHL_WR: begin
        we = 1'b1;
        wa = j[IW-1:0];
      end
      dpfa_pkg::OP_INSERT: begin
        we = 1'b1;
        wd.start = off;
        wd.len = cnt;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    vwe = (we && !is_pool_i) || (cmd.op == dpfa_pkg::OP_CLEAR);
    iwe = (we && is_pool_i) || (cmd.op == dpfa_pkg::OP_CLEAR);
    vwa = wa;
    iwa = wa;
    vwd = wd;
    iwd = wd;
    if (cmd.op == dpfa_pkg::OP_CLEAR) begin
      vwa = '0;
      iwa = '0;
      vwd.start = '0;
      vwd.len = max_v;
      iwd.start = '0;
      iwd.len = max_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwa] <= vwd;
    if (iwe) imem[iwa] <= iwd;
    vrd <= vmem[ra];
    ird <= imem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_v <= '0;
      max_i <= '0;
      vtot <= '0;
      itot <= '0;
      vused <= '0;
      iused <= '0;
      pools_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dpfa_pkg::REG_MAX_VERTICES: max_v <= cfg_data;
          dpfa_pkg::REG_MAX_INDICES:  max_i <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        dpfa_pkg::OP_SHL_END: begin
          if (is_pool_i) itot <= itot - TW'(1);
          else vtot <= vtot - TW'(1);
        end
        dpfa_pkg::OP_INSERT: begin
          if (is_pool_i) itot <= itot + TW'(1);
          else vtot <= vtot + TW'(1);
        end
        dpfa_pkg::OP_CLEAR: begin
          vtot <= TW'(max_v != '0);
          itot <= TW'(max_i != '0);
          vused <= '0;
          iused <= '0;
          pools_ready <= 1'b1;
        end
        dpfa_pkg::OP_FINISH: begin
          if (cmd.status == dpfa_pkg::ST_OK && item.command == dpfa_pkg::CMD_ALLOC) begin
            vused <= dpfa_pkg::add_sat(vused, item.vertex_count);
            iused <= dpfa_pkg::add_sat(iused, item.index_count);
          end else if (cmd.status == dpfa_pkg::ST_OK &&
                       item.command == dpfa_pkg::CMD_FREE) begin
            vused <= (vused > item.vertex_count) ? vused - item.vertex_count : '0;
            iused <= (iused > item.index_count) ? iused - item.index_count : '0;
          end
        end
        default: ;
      endcase
      if (cmd.op == dpfa_pkg::OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      dpfa_pkg::OP_LOAD: item <= in_data;
      dpfa_pkg::OP_START: begin
        idx <= '0;
        hit <= 1'b0;
      end
      dpfa_pkg::OP_TAKE_CHK: begin
        if (stat.len_ge) begin
          hit <= 1'b1;
          j <= idx;
          if (is_pool_i) ib <= rd.start;
          else vb <= rd.start;
        end else begin
          idx <= idxp1;
        end
      end
      dpfa_pkg::OP_LOC_CHK: begin
        if (stat.lt) begin
          prev <= rd;
          idx <= idxp1;
        end else begin
          cur <= rd;
        end
      end
      dpfa_pkg::OP_MERGE_BOTH: j <= idx;
      dpfa_pkg::OP_SHR_INIT: j <= total;
      dpfa_pkg::OP_SHR_WR: j <= jm1;
      dpfa_pkg::OP_SHL_WR: j <= jp1;
      dpfa_pkg::OP_FINISH: res_status <= cmd.status;
      dpfa_pkg::OP_CLEAR: res_status <= dpfa_pkg::ST_OK;
      dpfa_pkg::OP_OUT: begin
        out_data.status <= res_status;
        if (res_status == dpfa_pkg::ST_OK && item.command == dpfa_pkg::CMD_ALLOC) begin
          out_data.vertex_base <= vb[dpfa_pkg::BASE_W-1:0];
          out_data.index_base <= ib[dpfa_pkg::BASE_W-1:0];
        end else begin
          out_data.vertex_base <= '0;
          out_data.index_base <= '0;
        end
        out_data.vertices_in_use <= vused;
        out_data.indices_in_use <= iused;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/dual_pool_first_fit_allocator.sv]
// Vertex/index range allocator: two first-fit free lists of up to FREE_BLOCKS
// entries, each held in a single-port-read memory with registered read data.
// One command beat in, one result beat out. Every list entry visited by a
// scan or moved by a shift is read, then compared or written. An allocate
// scans the vertex pool, then the index pool, each plus any shift; when the
// index pool is exhausted the vertex range is given back with one more
// locate scan and any shift. A free runs four locate scans (check both
// pools, then apply) plus any shift. Allocates are rejected until the first
// clear. A new command is taken while the previous result still waits on
// the output.
`default_nettype none
`include "dual_pool_first_fit_allocator_defines.svh"
module dual_pool_first_fit_allocator #(
  parameter int FREE_BLOCKS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire dpfa_pkg::in_beat_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output dpfa_pkg::out_beat_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [dpfa_pkg::CNT_W-1:0] cfg_data
);

  dpfa_pkg::dp_cmd_t  dp_cmd;
  dpfa_pkg::dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  dpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  dpfa_datapath #(
    .FREE_BLOCKS (FREE_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  `DPFA_ASSERT_NXT(a_one_beat_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `DPFA_ASSERT_IMP(a_no_result_overwrite, clk, rst, dp_cmd.op == dpfa_pkg::OP_OUT,
                   !out_valid || out_ready)
  `DPFA_ASSERT_IMP(a_insert_has_room, clk, rst, dp_cmd.op == dpfa_pkg::OP_INSERT,
                   !dp_stat.list_full)

endmodule
`default_nettype wire

[bench/alloc_checker.sv]
`default_nettype none
module alloc_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire dpfa_pkg::in_beat_t         in_data,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire dpfa_pkg::out_beat_t        out_data,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [dpfa_pkg::CNT_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int CW = dpfa_pkg::CNT_W;
  localparam int BW = dpfa_pkg::BASE_W;

  logic [CW-1:0]       blk_start [2][DEPTH];
  logic [CW-1:0]       blk_len [2][DEPTH];
  int                  blk_cnt [2];
  bit                  pools_up;
  logic [CW-1:0]       vert_used, idx_used, vert_max, idx_max;
  dpfa_pkg::out_beat_t results_due[$];

  initial mismatches = 0;
  assign pending = results_due.size();

  function automatic logic [CW-1:0] clip_len(longint unsigned v);
    return (v > longint'(dpfa_pkg::LEN_MAX)) ? dpfa_pkg::LEN_MAX : v[CW-1:0];
  endfunction

  function automatic void drop_entry(dpfa_pkg::pool_t p, int pos);
    for (int i = pos; i + 1 < blk_cnt[p]; i++) begin
      blk_start[p][i] = blk_start[p][i+1];
      blk_len[p][i] = blk_len[p][i+1];
    end
    blk_cnt[p]--;
  endfunction

  function automatic bit carve(dpfa_pkg::pool_t p, logic [CW-1:0] cnt,
                               output logic [CW-1:0] base);
    base = '0;
    for (int i = 0; i < blk_cnt[p]; i++) begin
      if (blk_len[p][i] >= cnt) begin
        base = blk_start[p][i];
        if (blk_len[p][i] == cnt) begin
          drop_entry(p, i);
        end else begin
          blk_start[p][i] = blk_start[p][i] + cnt;
          blk_len[p][i] = blk_len[p][i] - cnt;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit find_slot(dpfa_pkg::pool_t p, logic [CW-1:0] off, logic [CW-1:0] cnt,
                                   output int pos, output bit mn, output bit mp);
    int i;
    i = 0;
    while (i < blk_cnt[p] && blk_start[p][i] < off) i++;
    pos = i;
    mn = (i < blk_cnt[p]) && (longint'(off) + longint'(cnt) == longint'(blk_start[p][i]));
    mp = (i > 0) &&
         (longint'(blk_start[p][i-1]) + longint'(blk_len[p][i-1]) == longint'(off));
    return mn || mp || blk_cnt[p] < DEPTH;
  endfunction

  function automatic bit has_room(dpfa_pkg::pool_t p, logic [CW-1:0] off, logic [CW-1:0] cnt);
    int pos;
    bit mn, mp;
    if (cnt == 0) return 1'b1;
    return find_slot(p, off, cnt, pos, mn, mp);
  endfunction

  function automatic void merge_in(dpfa_pkg::pool_t p, logic [CW-1:0] off, logic [CW-1:0] cnt);
    int pos;
    bit mn, mp;
    if (cnt == 0) return;
    if (!find_slot(p, off, cnt, pos, mn, mp)) return;
    if (mn && mp) begin
      blk_len[p][pos-1] = clip_len(longint'(blk_len[p][pos-1]) + longint'(cnt) +
                                   longint'(blk_len[p][pos]));
      drop_entry(p, pos);
    end else if (mn) begin
      blk_start[p][pos] = off;
      blk_len[p][pos] = clip_len(longint'(cnt) + longint'(blk_len[p][pos]));
    end else if (mp) begin
      blk_len[p][pos-1] = clip_len(longint'(blk_len[p][pos-1]) + longint'(cnt));
    end else begin
      for (int i = blk_cnt[p]; i > pos; i--) begin
        blk_start[p][i] = blk_start[p][i-1];
        blk_len[p][i] = blk_len[p][i-1];
      end
      blk_start[p][pos] = off;
      blk_len[p][pos] = cnt;
      blk_cnt[p]++;
    end
  endfunction

  function automatic void refill(dpfa_pkg::pool_t p, logic [CW-1:0] size);
    blk_cnt[p] = 0;
    if (size != 0) begin
      blk_start[p][0] = '0;
      blk_len[p][0] = size;
      blk_cnt[p] = 1;
    end
  endfunction

  function automatic logic [CW-1:0] add_clip(logic [CW-1:0] a, logic [CW-1:0] b);
    return clip_len(longint'(a) + longint'(b));
  endfunction

  function automatic dpfa_pkg::out_beat_t predict_result(dpfa_pkg::in_beat_t b);
    dpfa_pkg::out_beat_t r;
    logic [CW-1:0] vb, ib;
    logic [CW-1:0] vs, is;
    r = '0;
    r.status = dpfa_pkg::ST_IGNORED;
    vs = {1'b0, b.vertex_start};
    is = {1'b0, b.index_start};
    case (b.command)
      dpfa_pkg::CMD_ALLOC: begin
        if (!pools_up || b.vertex_count == 0 || b.index_count == 0) begin
          r.status = dpfa_pkg::ST_REJECTED;
        end else if (!carve(dpfa_pkg::POOL_V, b.vertex_count, vb)) begin
          r.status = dpfa_pkg::ST_VEXH;
        end else if (!carve(dpfa_pkg::POOL_I, b.index_count, ib)) begin
          merge_in(dpfa_pkg::POOL_V, vb, b.vertex_count);
          r.status = dpfa_pkg::ST_IEXH;
        end else begin
          r.status = dpfa_pkg::ST_OK;
          r.vertex_base = vb[BW-1:0];
          r.index_base = ib[BW-1:0];
          vert_used = add_clip(vert_used, b.vertex_count);
          idx_used = add_clip(idx_used, b.index_count);
        end
      end
      dpfa_pkg::CMD_FREE: begin
        if (!b.alloc_valid) begin
          r.status = dpfa_pkg::ST_IGNORED;
        end else if (!has_room(dpfa_pkg::POOL_V, vs, b.vertex_count) ||
                     !has_room(dpfa_pkg::POOL_I, is, b.index_count)) begin
          r.status = dpfa_pkg::ST_FULL;
        end else begin
          merge_in(dpfa_pkg::POOL_V, vs, b.vertex_count);
          merge_in(dpfa_pkg::POOL_I, is, b.index_count);
          vert_used = (vert_used > b.vertex_count) ? vert_used - b.vertex_count : '0;
          idx_used = (idx_used > b.index_count) ? idx_used - b.index_count : '0;
          r.status = dpfa_pkg::ST_OK;
        end
      end
      dpfa_pkg::CMD_CLEAR: begin
        refill(dpfa_pkg::POOL_V, vert_max);
        refill(dpfa_pkg::POOL_I, idx_max);
        vert_used = '0;
        idx_used = '0;
        pools_up = 1'b1;
        r.status = dpfa_pkg::ST_OK;
      end
      default: r.status = dpfa_pkg::ST_IGNORED;
    endcase
    r.vertices_in_use = vert_used;
    r.indices_in_use = idx_used;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      blk_cnt[dpfa_pkg::POOL_V] = 0;
      blk_cnt[dpfa_pkg::POOL_I] = 0;
      pools_up = 1'b0;
      vert_used = '0;
      idx_used = '0;
      vert_max = '0;
      idx_max = '0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dpfa_pkg::REG_MAX_VERTICES: vert_max = cfg_data;
          dpfa_pkg::REG_MAX_INDICES:  idx_max = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          dpfa_pkg::out_beat_t want;
          want = results_due.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("vertex_base", 64'(want.vertex_base), 64'(out_data.vertex_base));
          check_field("index_base", 64'(want.index_base), 64'(out_data.index_base));
          check_field("vertices_in_use", 64'(want.vertices_in_use),
                      64'(out_data.vertices_in_use));
          check_field("indices_in_use", 64'(want.indices_in_use),
                      64'(out_data.indices_in_use));
        end
      end
      if (in_valid && in_ready)
        results_due.insert(results_due.size(), predict_result(in_data));
    end
  end
endmodule
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = dpfa_pkg::CNT_W;
  localparam int BW = dpfa_pkg::BASE_W;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    dpfa_pkg::in_beat_t beat;
    int                 era;
  } sent_cmd_t;

  typedef struct {
    logic [BW-1:0] vb;
    logic [CW-1:0] vc;
    logic [BW-1:0] ib;
    logic [CW-1:0] ic;
  } range_pair_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  dpfa_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dpfa_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = dpfa_pkg::REG_MAX_VERTICES;
  logic [CW-1:0]       cfg_data = '0;
  int                  mismatches, pending;

  sent_cmd_t   cmd_log[$];
  range_pair_t live[$];
  int          era = 0;
  int          sent_cnt = 0, taken_cnt = 0, seen_cnt = 0, out_hold = 0;
  bit          no_gaps = 1'b0;

  dual_pool_first_fit_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  alloc_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // track returned ranges so frees can hand back real allocations
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      taken_cnt++;
      if (cmd_log.size() != 0) begin
        sent_cmd_t c;
        c = cmd_log.pop_front();
        if (c.beat.command == dpfa_pkg::CMD_ALLOC && out_data.status == dpfa_pkg::ST_OK &&
            c.era == era)
          live.insert(live.size(), '{out_data.vertex_base, c.beat.vertex_count,
                                     out_data.index_base, c.beat.index_count});
      end
    end
  end

  always @(negedge clk) begin
    if (seen_cnt != taken_cnt) begin
      seen_cnt = taken_cnt;
      out_hold = no_gaps ? 0 : $urandom_range(0, 18);
    end
    if (out_hold > 0) begin
      out_ready = 1'b0;
      out_hold--;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic send(dpfa_pkg::in_beat_t b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.command == dpfa_pkg::CMD_CLEAR) begin
      era++;
      live.delete();
    end
    cmd_log.insert(cmd_log.size(), '{b, era});
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (taken_cnt != sent_cnt) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_pools(logic [CW-1:0] nv, logic [CW-1:0] ni);
    drain();
    write_reg(dpfa_pkg::REG_MAX_VERTICES, nv);
    write_reg(dpfa_pkg::REG_MAX_INDICES, ni);
  endtask

  function automatic dpfa_pkg::in_beat_t mk(logic [1:0] cmd, logic [CW-1:0] vc,
                                            logic [CW-1:0] ic, logic [BW-1:0] vs,
                                            logic [BW-1:0] is, logic ok);
    dpfa_pkg::in_beat_t b;
    b.command = cmd;
    b.vertex_count = vc;
    b.index_count = ic;
    b.vertex_start = vs;
    b.index_start = is;
    b.alloc_valid = ok;
    return b;
  endfunction

  function automatic logic [CW-1:0] pick_count(int span);
    if ($urandom_range(0, 30) == 0) return CW'($urandom());
    if ($urandom_range(0, 20) == 0) return '0;
    return CW'($urandom_range(1, span));
  endfunction

  task automatic send_free_live(int k);
    range_pair_t r;
    r = live[k];
    live.delete(k);
    send(mk(dpfa_pkg::CMD_FREE, r.vc, r.ic, r.vb, r.ib, 1'b1));
  endtask

  task automatic random_item(int span);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      send(mk(dpfa_pkg::CMD_ALLOC, pick_count(span), pick_count(span), BW'($urandom()),
              BW'($urandom()), 1'($urandom())));
    end else if (roll < 80 && live.size() != 0) begin
      send_free_live($urandom_range(0, live.size() - 1));
    end else if (roll < 94) begin
      send(mk(dpfa_pkg::CMD_FREE, pick_count(span), pick_count(span), BW'($urandom()),
              BW'($urandom()), 1'($urandom())));
    end else if (roll < 97) begin
      send(mk(dpfa_pkg::CMD_CLEAR, CW'($urandom()), CW'($urandom()), BW'($urandom()),
              BW'($urandom()), 1'($urandom())));
    end else begin
      send(mk(CMD_UNKNOWN, CW'($urandom()), CW'($urandom()), BW'($urandom()),
              BW'($urandom()), 1'($urandom())));
    end
  endtask

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int span;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(mk(dpfa_pkg::CMD_ALLOC, 1, 1, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_FREE, 5, 5, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_FREE, 5, 5, 0, 0, 1'b1));
    send(mk(CMD_UNKNOWN, '1, '1, '1, '1, 1'b1));
    send(mk(dpfa_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0));
    set_pools(1000, 500);
    send(mk(dpfa_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, 0, 5, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, 5, 0, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, 100, 50, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, 2000, 1, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, 10, 600, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, 900, 450, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_FREE, 100, 50, 0, 0, 1'b1));
    send(mk(dpfa_pkg::CMD_FREE, 0, 7, 3, 60, 1'b1));
    send(mk(dpfa_pkg::CMD_FREE, 5, 5, 10, 10, 1'b1));
    send(mk(dpfa_pkg::CMD_FREE, '1, '1, '1, '1, 1'b1));
    send(mk(dpfa_pkg::CMD_FREE, 25'h1000000, 25'h1000000, 0, 0, 1'b1));
    set_pools(25'h1000000, '1);
    send(mk(dpfa_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, 25'h1000000, 25'h1000000, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, '1, '1, 0, 0, 1'b0));
    send(mk(dpfa_pkg::CMD_ALLOC, 1, 1, 0, 0, 1'b0));

    // fragment both lists until they overflow
    set_pools(200, 200);
    no_gaps = 1'b0;
    send(mk(dpfa_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0));
    repeat (150) send(mk(dpfa_pkg::CMD_ALLOC, 1, 1, BW'($urandom()), BW'($urandom()), 1'b0));
    drain();
    for (int k = live.size() - 1; k >= 0; k -= 2) send_free_live(k);
    repeat (60) random_item(3);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin set_pools(64, 64); span = 8; end
        1: begin
          set_pools(CW'($urandom_range(100, 5000)), CW'($urandom_range(100, 5000)));
          span = 300;
        end
        2: begin set_pools(0, 300); span = 20; end
        3: begin set_pools('1, 25'h1000000); span = 1 << 20; end
        default: begin set_pools(CW'($urandom()), CW'($urandom())); span = 40; end
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      send(mk(dpfa_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0));
      repeat (110) random_item(span);
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
